[src/pointer_stroke_drag_classifier_macros.svh]
// Assertion macros shared by the pointer stroke and drag classifier.
`ifndef POINTER_STROKE_DRAG_CLASSIFIER_MACROS_SVH
`define POINTER_STROKE_DRAG_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSDC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PSDC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PSDC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PSDC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/psdc_pkg.sv]
// Types, constants and helpers of the pointer stroke and drag classifier.
package psdc_pkg;

	localparam int COORD_W         = 16;
	localparam int TIME_W          = 32;
	localparam int SPEED_W         = 24;
	localparam int SPEED_FRAC_BITS = 4;
	localparam int BUDGET_W        = 16;
	localparam int RMIN_W          = 12;
	localparam int TAU_W           = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(16);
	localparam logic [RMIN_W-1:0]   RMIN_RESET   = RMIN_W'(12);
	localparam logic [TAU_W-1:0]    TAU_RESET    = TAU_W'(100);

	// Coordinate differences and the square root that measures distance.
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SQ_SUM_W   = SQ_W + 1;
	localparam int SQ_RAD_RAW = SQ_SUM_W + 2 * SPEED_FRAC_BITS;
	localparam int SQ_RAD_W   = 2 * ((SQ_RAD_RAW + 1) / 2);
	localparam int SQ_STEPS   = SQ_RAD_W / 2;
	localparam int DIST_W     = SQ_STEPS;
	localparam int SREM_W     = SQ_STEPS + 2;

	// Instant speed: distance times 1000 over the time step.
	localparam int MS_PER_S = 1000;
	localparam int MS_W     = 10;
	localparam int DIVD_W   = DIST_W + MS_W;
	localparam int DIV_W    = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

	// Decay polynomial in Q32.
	localparam int Q32_BITS     = 32;
	localparam int LIMIT_SHIFT  = 4;
	localparam int X_SHIFT      = 16;
	localparam int X_W          = X_SHIFT + LIMIT_SHIFT;
	localparam int Y_SHIFT      = 8;
	localparam int Y_W          = X_W + Y_SHIFT;
	localparam int Y2_W         = 2 * Y_W - Q32_BITS;
	localparam int Y3_W         = Y2_W + Y_W - Q32_BITS;
	localparam int RECIP6_W     = 22;
	localparam int RECIP6_SHIFT = 24;
	localparam logic [RECIP6_W-1:0] RECIP6 = RECIP6_W'(2796203);
	localparam int Q6_W         = Y3_W + RECIP6_W - RECIP6_SHIFT;
	localparam int SQUARINGS    = 8;
	localparam logic [Q32_BITS:0]   ONE_Q32  = {1'b1, {Q32_BITS{1'b0}}};
	localparam logic [Q32_BITS-1:0] HALF_Q32 = {1'b1, {(Q32_BITS-1){1'b0}}};

	localparam int CNT_W = $clog2(SQ_STEPS + 1);

	typedef enum logic [1:0] {
		MODE_PRESS,
		MODE_MOVE,
		MODE_RELEASE,
		MODE_CANCEL
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_UNDECIDED,
		PH_STROKING,
		PH_DRAGGING
	} phase_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUDGET,
		CFG_REV_MIN,
		CFG_TAU
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQR_MUL,
		ST_SQR_INIT,
		ST_SQRT,
		ST_DIVI_GO,
		ST_DIVI_WAIT,
		ST_DECAY_CHK,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_POLY1,
		ST_POLY2,
		ST_POLY3,
		ST_POLY4,
		ST_SQUARE,
		ST_BLEND1,
		ST_BLEND2,
		ST_BLEND3,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic sq_mul;
		logic sq_init;
		logic sq_step;
		logic divi_start;
		logic inst_take;
		logic divx_start;
		logic x_take;
		logic d_zero;
		logic poly1;
		logic poly2;
		logic poly3;
		logic poly4;
		logic p_square;
		logic blend1;
		logic blend2;
		logic blend3;
		logic out_load;
	} psdc_cmd_t;

	typedef struct packed {
		logic run_speed;
		logic d_skip;
		logic div_done;
	} psdc_status_t;

	function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(a) - DIFF_W'(b);
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

endpackage

[src/psdc_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module psdc_div
	import psdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIV_W-1:0]      rem_init,
	input  logic [DIVD_W-1:0]     dividend,
	input  logic [DIV_CNT_W-1:0]  steps,
	input  logic [DIV_W-1:0]      divisor,
	output logic [DIVD_W-1:0]     quotient,
	output logic                  done
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIVD_W-1:0]    shr_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, shr_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			shr_q <= dividend;
			quo_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
			shr_q <= {shr_q[DIVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[src/psdc_ctrl.sv]
// Sequencer of the classifier: steps the datapath through one item.
module psdc_ctrl
	import psdc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  psdc_status_t st,
	output psdc_cmd_t    cmd
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	logic             out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = st.run_speed ? ST_SQR_MUL : ST_FINISH;
				end
			end
			ST_SQR_MUL:  state_d = ST_SQR_INIT;
			ST_SQR_INIT: state_d = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
					state_d = ST_DIVI_GO;
				end
			end
			ST_DIVI_GO: state_d = ST_DIVI_WAIT;
			ST_DIVI_WAIT: begin
				if (st.div_done) begin
					state_d = ST_DECAY_CHK;
				end
			end
			ST_DECAY_CHK: state_d = st.d_skip ? ST_BLEND1 : ST_DIVX_GO;
			ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
			ST_DIVX_WAIT: begin
				if (st.div_done) begin
					state_d = ST_POLY1;
				end
			end
			ST_POLY1: state_d = ST_POLY2;
			ST_POLY2: state_d = ST_POLY3;
			ST_POLY3: state_d = ST_POLY4;
			ST_POLY4: state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (cnt_q == CNT_W'(SQUARINGS - 1)) begin
					state_d = ST_BLEND1;
				end
			end
			ST_BLEND1: state_d = ST_BLEND2;
			ST_BLEND2: state_d = ST_BLEND3;
			ST_BLEND3: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_SQR_MUL:   cmd.sq_mul     = 1'b1;
			ST_SQR_INIT:  cmd.sq_init    = 1'b1;
			ST_SQRT:      cmd.sq_step    = 1'b1;
			ST_DIVI_GO:   cmd.divi_start = 1'b1;
			ST_DIVI_WAIT: cmd.inst_take  = st.div_done;
			ST_DECAY_CHK: cmd.d_zero     = st.d_skip;
			ST_DIVX_GO:   cmd.divx_start = 1'b1;
			ST_DIVX_WAIT: cmd.x_take     = st.div_done;
			ST_POLY1:     cmd.poly1      = 1'b1;
			ST_POLY2:     cmd.poly2      = 1'b1;
			ST_POLY3:     cmd.poly3      = 1'b1;
			ST_POLY4:     cmd.poly4      = 1'b1;
			ST_SQUARE:    cmd.p_square   = 1'b1;
			ST_BLEND1:    cmd.blend1     = 1'b1;
			ST_BLEND2:    cmd.blend2     = 1'b1;
			ST_BLEND3:    cmd.blend3     = 1'b1;
			ST_FINISH:    cmd.out_load   = out_free;
			default:      cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQR_INIT || state_q == ST_POLY4) begin
				cnt_q <= '0;
			end else if (state_q == ST_SQRT || state_q == ST_SQUARE) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

[src/psdc_dp.sv]
// Datapath of the classifier: gesture state, square root, decay and blend.
module psdc_dp
	import psdc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  psdc_cmd_t                   cmd,
	output psdc_status_t                st,
	input  mode_t                       mode,
	input  logic signed [COORD_W-1:0]   pos_x,
	input  logic signed [COORD_W-1:0]   pos_y,
	input  logic [TIME_W-1:0]           time_ms,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output phase_t                      phase,
	output logic                        stroke_pulse,
	output logic                        drag_started,
	output logic [SPEED_W-1:0]          speed
);

	// Configuration.
	logic [BUDGET_W-1:0] budget_q;
	logic [RMIN_W-1:0]   rev_min_q;
	logic [TAU_W-1:0]    tau_q;

	// Gesture state.
	phase_t                    phase_q;
	dir_t                      dir_q;
	logic [1:0]                rev_cnt_q;
	logic signed [COORD_W-1:0] press_x_q, press_y_q, last_x_q, last_y_q, ext_x_q;
	logic [TIME_W-1:0]         last_time_q;
	logic [SPEED_W-1:0]        avg_q;

	// Result of the item in work.
	phase_t res_phase_q;
	logic   res_pulse_q;
	logic   res_drag_q;

	// Speed path.
	logic [TIME_W-1:0]   dt_q;
	logic [DIFF_W-1:0]   dx_q, dy_q;
	logic [SQ_W-1:0]     sqx_s1, sqy_s1;
	logic [SQ_RAD_W-1:0] rad_q;
	logic [DIST_W-1:0]   root_q;
	logic [SREM_W-1:0]   srem_q;
	logic [SPEED_W-1:0]  inst_q;
	logic [X_W-1:0]      x_q;
	logic [Y2_W-1:0]     y2_q;
	logic [Y3_W-1:0]     y3_q;
	logic [Q6_W-1:0]     q6_q;
	logic [Q32_BITS-1:0] p_q;
	logic [SPEED_W+Q32_BITS:0]   ma_s1;
	logic [SPEED_W+Q32_BITS-1:0] mb_s1;

	// Output register.
	phase_t             out_phase_q;
	logic               out_pulse_q;
	logic               out_drag_q;
	logic [SPEED_W-1:0] out_speed_q;

	// Classification of the incoming item.
	phase_t              cls_phase, shown;
	dir_t                cls_dir;
	logic [1:0]          cls_cnt, cnt_inc;
	logic signed [COORD_W-1:0] cls_ext;
	logic                cls_pulse, cls_drag, rev;
	logic [DIFF_W-1:0]   fx_abs, fy_abs, rmin_w;
	logic [DIFF_W:0]     manhattan;
	logic                active, lt_ok;

	assign fx_abs    = abs_diff(pos_x, press_x_q);
	assign fy_abs    = abs_diff(pos_y, press_y_q);
	assign manhattan = {1'b0, fx_abs} + {1'b0, fy_abs};
	assign rmin_w    = DIFF_W'(rev_min_q);
	assign cnt_inc   = (rev_cnt_q == 2'd2) ? 2'd2 : rev_cnt_q + 2'd1;
	assign active    = phase_q != PH_IDLE;
	assign lt_ok     = (last_time_q != '0) && (time_ms > last_time_q);

	always_comb begin
		cls_phase = phase_q;
		cls_dir   = dir_q;
		cls_ext   = ext_x_q;
		cls_cnt   = rev_cnt_q;
		cls_pulse = 1'b0;
		cls_drag  = 1'b0;
		rev       = 1'b0;
		case (mode)
			MODE_PRESS: begin
				cls_phase = PH_UNDECIDED;
				cls_dir   = DIR_NONE;
				cls_ext   = pos_x;
				cls_cnt   = 2'd0;
			end
			MODE_MOVE: begin
				if (active && phase_q != PH_DRAGGING) begin
					if (phase_q == PH_UNDECIDED &&
							manhattan >= (DIFF_W + 1)'(budget_q)) begin
						cls_phase = PH_DRAGGING;
						cls_drag  = 1'b1;
					end else begin
						case (dir_q)
							DIR_NONE: begin
								if (fx_abs >= rmin_w) begin
									cls_dir = (pos_x > press_x_q) ? DIR_UP : DIR_DOWN;
									cls_ext = pos_x;
								end
							end
							DIR_UP: begin
								if (pos_x >= ext_x_q) begin
									cls_ext = pos_x;
								end else if (abs_diff(ext_x_q, pos_x) >= rmin_w) begin
									cls_dir = DIR_DOWN;
									cls_ext = pos_x;
									rev     = 1'b1;
								end
							end
							DIR_DOWN: begin
								if (pos_x <= ext_x_q) begin
									cls_ext = pos_x;
								end else if (abs_diff(pos_x, ext_x_q) >= rmin_w) begin
									cls_dir = DIR_UP;
									cls_ext = pos_x;
									rev     = 1'b1;
								end
							end
							default: cls_dir = dir_q;
						endcase
						if (rev) begin
							cls_cnt = cnt_inc;
							if (cnt_inc == 2'd2) begin
								cls_pulse = 1'b1;
								if (phase_q == PH_UNDECIDED) begin
									cls_phase = PH_STROKING;
								end
							end
						end
					end
				end
			end
			MODE_RELEASE, MODE_CANCEL: begin
				cls_phase = PH_IDLE;
				cls_dir   = DIR_NONE;
				cls_cnt   = 2'd0;
			end
			default: cls_phase = phase_q;
		endcase
	end

	assign shown = (mode == MODE_RELEASE) ? phase_q : cls_phase;

	assign st.run_speed = lt_ok && active &&
		(mode == MODE_MOVE || (mode == MODE_RELEASE && phase_q != PH_UNDECIDED));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= BUDGET_RESET;
			rev_min_q <= RMIN_RESET;
			tau_q     <= TAU_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUDGET:  budget_q  <= cfg_data[BUDGET_W-1:0];
				CFG_REV_MIN: rev_min_q <= cfg_data[RMIN_W-1:0];
				CFG_TAU:     tau_q     <= cfg_data[TAU_W-1:0];
				default:     tau_q     <= tau_q;
			endcase
		end
	end

	// Gesture state and the speed average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			dir_q       <= DIR_NONE;
			rev_cnt_q   <= 2'd0;
			press_x_q   <= '0;
			press_y_q   <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			ext_x_q     <= '0;
			last_time_q <= '0;
			avg_q       <= '0;
		end else begin
			if (cmd.capture) begin
				phase_q   <= cls_phase;
				dir_q     <= cls_dir;
				rev_cnt_q <= cls_cnt;
				ext_x_q   <= cls_ext;
				if (mode == MODE_PRESS) begin
					press_x_q   <= pos_x;
					press_y_q   <= pos_y;
					last_x_q    <= pos_x;
					last_y_q    <= pos_y;
					last_time_q <= time_ms;
				end else if (mode == MODE_MOVE && active) begin
					last_x_q    <= pos_x;
					last_y_q    <= pos_y;
					last_time_q <= time_ms;
				end
				// A press, a cancel or the release of an undecided press zeroes the average.
				if (mode == MODE_PRESS || mode == MODE_CANCEL ||
						(mode == MODE_RELEASE && phase_q == PH_UNDECIDED)) begin
					avg_q <= '0;
				end
			end else if (cmd.blend3) begin
				avg_q <= SPEED_W'(({1'b0, ma_s1} + (SPEED_W + Q32_BITS + 1)'(mb_s1) +
					(SPEED_W + Q32_BITS + 1)'(HALF_Q32)) >> Q32_BITS);
			end
		end
	end

	// Square root, one result bit per step.
	logic [SREM_W+1:0] sq_t;
	logic [SREM_W+1:0] sq_trial;
	logic              sq_ge;

	assign sq_t     = {srem_q, rad_q[SQ_RAD_W-1 -: 2]};
	assign sq_trial = (SREM_W + 2)'({root_q, 2'b01});
	assign sq_ge    = sq_t >= sq_trial;

	// Shared divider.
	logic                 div_start, div_done;
	logic [DIV_W-1:0]     div_rem_init, div_divisor;
	logic [DIVD_W-1:0]    div_dividend, div_quo;
	logic [DIV_CNT_W-1:0] div_steps;

	assign div_start = cmd.divi_start || cmd.divx_start;

	always_comb begin
		if (cmd.divx_start) begin
			// Decay ratio (dt << 16) / tau; dt >> 4 is already below tau.
			div_rem_init = dt_q >> LIMIT_SHIFT;
			div_dividend = DIVD_W'({dt_q[LIMIT_SHIFT-1:0], {X_SHIFT{1'b0}}}) << (DIVD_W - X_W);
			div_steps    = DIV_CNT_W'(X_W);
			div_divisor  = DIV_W'(tau_q);
		end else begin
			div_rem_init = '0;
			div_dividend = DIVD_W'(root_q * MS_W'(MS_PER_S));
			div_steps    = DIV_CNT_W'(DIVD_W);
			div_divisor  = dt_q;
		end
	end

	psdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.dividend (div_dividend),
		.steps    (div_steps),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign st.div_done = div_done;
	assign st.d_skip   = (tau_q == '0) ||
		(dt_q >= (TIME_W'(tau_q) << LIMIT_SHIFT));

	logic [Y_W-1:0]             y_val;
	logic [2*Y_W-1:0]           y_sq;
	logic [Y2_W+Y_W-1:0]        y_cube;
	logic [Y3_W+RECIP6_W-1:0]   y_div6;
	logic [Q32_BITS:0]          p_poly;
	logic [2*Q32_BITS-1:0]      p_sq;

	assign y_val  = {x_q, {Y_SHIFT{1'b0}}};
	assign y_sq   = y_val * y_val;
	assign y_cube = y2_q * y_val;
	assign y_div6 = y3_q * RECIP6;
	assign p_poly = ONE_Q32 - (Q32_BITS + 1)'(y_val) + (Q32_BITS + 1)'(y2_q >> 1) -
		(Q32_BITS + 1)'(q6_q);
	assign p_sq   = p_q * p_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dt_q        <= time_ms - last_time_q;
			dx_q        <= (mode == MODE_MOVE) ? abs_diff(pos_x, last_x_q) : '0;
			dy_q        <= (mode == MODE_MOVE) ? abs_diff(pos_y, last_y_q) : '0;
			res_phase_q <= shown;
			res_pulse_q <= cls_pulse;
			res_drag_q  <= cls_drag;
		end
		if (cmd.sq_mul) begin
			sqx_s1 <= dx_q * dx_q;
			sqy_s1 <= dy_q * dy_q;
		end
		if (cmd.sq_init) begin
			rad_q  <= SQ_RAD_W'({1'b0, sqx_s1} + {1'b0, sqy_s1}) << (2 * SPEED_FRAC_BITS);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q  <= rad_q << 2;
			srem_q <= sq_ge ? SREM_W'(sq_t - sq_trial) : SREM_W'(sq_t);
			root_q <= {root_q[DIST_W-2:0], sq_ge};
		end
		if (cmd.inst_take) begin
			inst_q <= (div_quo > DIVD_W'({SPEED_W{1'b1}})) ? {SPEED_W{1'b1}} :
				div_quo[SPEED_W-1:0];
		end
		if (cmd.x_take) begin
			x_q <= div_quo[X_W-1:0];
		end
		if (cmd.poly1) begin
			y2_q <= y_sq[2*Y_W-1:Q32_BITS];
		end
		if (cmd.poly2) begin
			y3_q <= y_cube[Y2_W+Y_W-1:Q32_BITS];
		end
		if (cmd.poly3) begin
			q6_q <= y_div6[Y3_W+RECIP6_W-1:RECIP6_SHIFT];
		end
		if (cmd.d_zero) begin
			p_q <= '0;
		end else if (cmd.poly4) begin
			p_q <= p_poly[Q32_BITS-1:0];
		end else if (cmd.p_square) begin
			p_q <= p_sq[2*Q32_BITS-1:Q32_BITS];
		end
		if (cmd.blend1) begin
			ma_s1 <= inst_q * (ONE_Q32 - {1'b0, p_q});
		end
		if (cmd.blend2) begin
			mb_s1 <= avg_q * p_q;
		end
		if (cmd.out_load) begin
			out_phase_q <= res_phase_q;
			out_pulse_q <= res_pulse_q;
			out_drag_q  <= res_drag_q;
			out_speed_q <= avg_q;
		end
	end

	assign phase        = out_phase_q;
	assign stroke_pulse = out_pulse_q;
	assign drag_started = out_drag_q;
	assign speed        = out_speed_q;

endmodule

[src/pointer_stroke_drag_classifier.sv]
// Top level of the pointer stroke and drag classifier.
//
//  channel   signals                                  carries
//  s_        s_tvalid s_tready s_tdata s_tuser        pointer events
//  m_        m_tvalid m_tready m_tdata                one result per event
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data   threshold registers
//
// An event that leaves the speed average alone goes from accept to the finish state. In a
// speed update the serial square root runs 22 steps, the shared radix-2 divider 32 steps
// for the instant speed and 20 for the decay ratio, then the cubic and eight decay
// squarings; the ratio, cubic and squarings are skipped when the decay is zero. One event
// is in work at a time; the next is accepted while a result waits in the output register.
// Reset clears the gesture state and loads the default thresholds.
`include "pointer_stroke_drag_classifier_macros.svh"

module pointer_stroke_drag_classifier
	import psdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // pos_x, pos_y, time_ms
	input  logic [1:0]            s_tuser,   // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // phase, stroke_pulse, drag_started, speed
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	psdc_cmd_t          cmd;
	psdc_status_t       st;
	phase_t             phase;
	logic               stroke_pulse;
	logic               drag_started;
	logic [SPEED_W-1:0] speed;

	assign cfg_ready = 1'b1;

	psdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	psdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.mode         (mode_t'(s_tuser)),
		.pos_x        (s_tdata[COORD_W-1:0]),
		.pos_y        (s_tdata[2*COORD_W-1:COORD_W]),
		.time_ms      (s_tdata[2*COORD_W+TIME_W-1:2*COORD_W]),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.phase        (phase),
		.stroke_pulse (stroke_pulse),
		.drag_started (drag_started),
		.speed        (speed)
	);

	assign m_tdata = {4'b0, speed, drag_started, stroke_pulse, phase};

	`PSDC_ASSERT_NXT(a_single_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "item accepted while another is in work")
	`PSDC_ASSERT_IMP(a_flags_apart, clk, arst_n, m_tvalid, !(stroke_pulse && drag_started), "stroke pulse and drag start together")
	`PSDC_ASSERT_IMP(a_drag_phase, clk, arst_n, m_tvalid && drag_started, phase == PH_DRAGGING, "drag start outside dragging phase")
	`PSDC_ASSERT_IMP(a_pulse_phase, clk, arst_n, m_tvalid && stroke_pulse, phase == PH_STROKING, "stroke pulse outside stroking phase")

endmodule
